// ----- sv/bpr_pkg.sv -----
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants for the bitmap pixel to RGB32 converter.
// ----------------------------------------------------------------------------
package bpr_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int PALETTE_SIZE = 256;

    localparam int DIM_W     = 13;
    localparam int DIM_MAX   = (1 << DIM_W) - 1;
    localparam int EFF_MAX   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int COL_W     = $clog2(EFF_MAX);
    localparam int PAL_AW    = $clog2(PALETTE_SIZE);
    localparam int PAL_CNT_W = $clog2(4 * PALETTE_SIZE);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [15:0] RGB555_R_MASK = 16'h7C00;
    localparam logic [15:0] RGB555_G_MASK = 16'h03E0;
    localparam logic [15:0] RGB555_B_MASK = 16'h001F;

    typedef enum logic [1:0] {
        DEPTH_PAL8   = 2'd0,
        DEPTH_RGB555 = 2'd1,
        DEPTH_BGR24  = 2'd2,
        DEPTH_RAW32  = 2'd3
    } depth_t;

    typedef enum logic [2:0] {
        PH_PALETTE = 3'b001,
        PH_PIXELS  = 3'b010,
        PH_PAD     = 3'b100
    } phase_t;

    typedef struct packed {
        logic [2:0]        pal_we;
        logic [PAL_AW-1:0] pal_waddr;
        logic [7:0]        pal_wdata;
        logic              pal_re;
        logic [PAL_AW-1:0] pal_raddr;
        logic              emit;
        logic              use_pal;
        logic [31:0]       word;
        logic              last;
    } ctrl_t;

endpackage

// ----- sv/bpr_ram.sv -----
// ----------------------------------------------------------------------------
// bpr_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/bpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpr_ctrl
// Stream sequencer: configuration registers, palette load, pixel assembly,
// column/row tracking and row padding skip.
// ----------------------------------------------------------------------------
module bpr_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [7:0]                      data_byte,
    input  logic                            cfg_valid,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpr_pkg::DIM_W-1:0]       cfg_data,
    output bpr_pkg::ctrl_t                  ctl
);

    bpr_pkg::depth_t                   depth_reg, depth_next;
    logic [bpr_pkg::COL_W-1:0]         wm1_reg, wm1_next;
    logic [1:0]                        wlo_reg, wlo_next;
    logic [bpr_pkg::DIM_W-1:0]         hm1_reg, hm1_next;
    bpr_pkg::phase_t                   phase_reg, phase_next;
    logic [bpr_pkg::PAL_CNT_W-1:0]     pal_cnt_reg, pal_cnt_next;
    logic [1:0]                        bip_reg, bip_next;
    logic [23:0]                       asm_reg, asm_next;
    logic [bpr_pkg::COL_W-1:0]         col_reg, col_next;
    logic [1:0]                        pad_reg, pad_next;
    logic [bpr_pkg::DIM_W-1:0]         row_reg, row_next;

    logic                              restart;
    bpr_pkg::depth_t                   restart_depth;
    logic [bpr_pkg::DIM_W-1:0]         eff_w;
    logic [2:0]                        bpp;
    logic [2:0]                        row_bytes_lo;
    logic [1:0]                        pad_amt;
    logic [15:0]                       v555;
    logic [4:0]                        r5, g5, b5;

    always_comb begin
        if (cfg_data == '0) begin
            eff_w = bpr_pkg::DIM_W'(1);
        end else if (cfg_data > bpr_pkg::DIM_W'(bpr_pkg::EFF_MAX)) begin
            eff_w = bpr_pkg::DIM_W'(bpr_pkg::EFF_MAX);
        end else begin
            eff_w = cfg_data;
        end
    end

    assign bpp          = {1'b0, depth_reg} + 3'd1;
    assign row_bytes_lo = 3'(bpp * {1'b0, wlo_reg});
    assign pad_amt      = 2'(2'd0 - row_bytes_lo[1:0]);

    assign v555 = {data_byte, asm_reg[7:0]};
    assign r5   = 5'((v555 & bpr_pkg::RGB555_R_MASK) >> 10);
    assign g5   = 5'((v555 & bpr_pkg::RGB555_G_MASK) >> 5);
    assign b5   = 5'(v555 & bpr_pkg::RGB555_B_MASK);

    always_comb begin
        depth_next    = depth_reg;
        wm1_next      = wm1_reg;
        wlo_next      = wlo_reg;
        hm1_next      = hm1_reg;
        phase_next    = phase_reg;
        pal_cnt_next  = pal_cnt_reg;
        bip_next      = bip_reg;
        asm_next      = asm_reg;
        col_next      = col_reg;
        pad_next      = pad_reg;
        row_next      = row_reg;
        restart       = 1'b0;
        restart_depth = depth_reg;

        ctl           = '0;
        ctl.pal_waddr = pal_cnt_reg[bpr_pkg::PAL_CNT_W-1:2];
        ctl.pal_wdata = data_byte;
        ctl.pal_raddr = data_byte[bpr_pkg::PAL_AW-1:0];
        ctl.use_pal   = (depth_reg == bpr_pkg::DEPTH_PAL8);
        ctl.last      = (col_reg == wm1_reg) && (row_reg == hm1_reg);

        unique case (depth_reg)
            bpr_pkg::DEPTH_PAL8:   ctl.word = '0;
            bpr_pkg::DEPTH_RGB555: ctl.word = {8'h00, 3'b000, b5, 3'b000, g5, 3'b000, r5};
            bpr_pkg::DEPTH_BGR24:  ctl.word = {8'h00, asm_reg[7:0], asm_reg[15:8], data_byte};
            bpr_pkg::DEPTH_RAW32:  ctl.word = {data_byte, asm_reg};
            default:               ctl.word = '0;
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                bpr_pkg::REG_DEPTH: begin
                    depth_next    = bpr_pkg::depth_t'(cfg_data[1:0]);
                    restart_depth = bpr_pkg::depth_t'(cfg_data[1:0]);
                    restart       = 1'b1;
                end
                bpr_pkg::REG_WIDTH: begin
                    wm1_next = bpr_pkg::COL_W'(eff_w - bpr_pkg::DIM_W'(1));
                    wlo_next = eff_w[1:0];
                    restart  = 1'b1;
                end
                bpr_pkg::REG_HEIGHT: begin
                    hm1_next = (cfg_data == '0) ? '0 : cfg_data - bpr_pkg::DIM_W'(1);
                    restart  = 1'b1;
                end
                default: ;
            endcase
        end else if (accept) begin
            unique case (phase_reg)
                bpr_pkg::PH_PALETTE: begin
                    case (pal_cnt_reg[1:0])
                        2'd0:    ctl.pal_we = 3'b001;
                        2'd1:    ctl.pal_we = 3'b010;
                        2'd2:    ctl.pal_we = 3'b100;
                        default: ctl.pal_we = 3'b000;
                    endcase
                    pal_cnt_next = pal_cnt_reg + bpr_pkg::PAL_CNT_W'(1);
                    if (&pal_cnt_reg) begin
                        phase_next = bpr_pkg::PH_PIXELS;
                    end
                end
                bpr_pkg::PH_PAD: begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1) begin
                        if (row_reg == hm1_reg) begin
                            restart = 1'b1;
                        end else begin
                            row_next   = row_reg + bpr_pkg::DIM_W'(1);
                            phase_next = bpr_pkg::PH_PIXELS;
                        end
                    end
                end
                bpr_pkg::PH_PIXELS: begin
                    if (bip_reg != depth_reg) begin
                        case (bip_reg)
                            2'd0:    asm_next[7:0]   = data_byte;
                            2'd1:    asm_next[15:8]  = data_byte;
                            default: asm_next[23:16] = data_byte;
                        endcase
                        bip_next = bip_reg + 2'd1;
                    end else begin
                        ctl.emit   = 1'b1;
                        ctl.pal_re = ctl.use_pal;
                        bip_next   = '0;
                        asm_next   = '0;
                        if (col_reg == wm1_reg) begin
                            col_next = '0;
                            if (pad_amt != 2'd0) begin
                                pad_next   = pad_amt;
                                phase_next = bpr_pkg::PH_PAD;
                            end else if (row_reg == hm1_reg) begin
                                restart = 1'b1;
                            end else begin
                                row_next = row_reg + bpr_pkg::DIM_W'(1);
                            end
                        end else begin
                            col_next = col_reg + bpr_pkg::COL_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end

        if (restart) begin
            phase_next   = (restart_depth == bpr_pkg::DEPTH_PAL8) ?
                           bpr_pkg::PH_PALETTE : bpr_pkg::PH_PIXELS;
            pal_cnt_next = '0;
            bip_next     = '0;
            asm_next     = '0;
            col_next     = '0;
            pad_next     = '0;
            row_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= bpr_pkg::DEPTH_RAW32;
            wm1_reg     <= '0;
            wlo_reg     <= 2'd1;
            hm1_reg     <= '0;
            phase_reg   <= bpr_pkg::PH_PIXELS;
            pal_cnt_reg <= '0;
            bip_reg     <= '0;
            asm_reg     <= '0;
            col_reg     <= '0;
            pad_reg     <= '0;
            row_reg     <= '0;
        end else begin
            depth_reg   <= depth_next;
            wm1_reg     <= wm1_next;
            wlo_reg     <= wlo_next;
            hm1_reg     <= hm1_next;
            phase_reg   <= phase_next;
            pal_cnt_reg <= pal_cnt_next;
            bip_reg     <= bip_next;
            asm_reg     <= asm_next;
            col_reg     <= col_next;
            pad_reg     <= pad_next;
            row_reg     <= row_next;
        end
    end

endmodule

// ----- sv/bitmap_pixels_to_rgb32.sv -----
// ----------------------------------------------------------------------------
// bitmap_pixels_to_rgb32
// Converts the raw pixel byte stream of an uncompressed bitmap into 32-bit
// color words, one per pixel, with a flag on the last pixel of the image.
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle; the input only stalls when the result
// side holds off m_ready with both the read stage and the output register
// full. A pixel's word passes the read stage and then the output register on
// its way to m_valid; the read stage covers the registered palette read
// (three 256 x 8 RAMs, one per colour lane). At 8-bit depth the first 1024
// bytes of each image load the palette and give no transaction; row padding
// bytes are consumed silently. The palette has no reset and no clearing pass.
// A configuration write restarts the stream and must only be made while idle.
// ----------------------------------------------------------------------------
module bitmap_pixels_to_rgb32 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_pixel_word,
    output logic                          m_last_pixel,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpr_pkg::DIM_W-1:0]     cfg_data
);

    bpr_pkg::ctrl_t ctl;
    logic           accept;
    logic           out_free;
    logic [7:0]     pal_r, pal_g, pal_b;

    logic           s1_valid_reg, s1_valid_next;
    logic           s1_pal_reg;
    logic [31:0]    s1_word_reg;
    logic           s1_last_reg;
    logic           m_valid_reg, m_valid_next;
    logic [31:0]    m_word_reg;
    logic           m_last_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || out_free;
    assign accept    = s_valid && s_ready;

    bpr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_data_byte),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl)
    );

    bpr_ram #(.WIDTH(8), .DEPTH(bpr_pkg::PALETTE_SIZE)) u_ram_b (
        .aclk  (aclk),
        .we    (ctl.pal_we[0]),
        .waddr (ctl.pal_waddr),
        .wdata (ctl.pal_wdata),
        .re    (ctl.pal_re),
        .raddr (ctl.pal_raddr),
        .rdata (pal_b)
    );

    bpr_ram #(.WIDTH(8), .DEPTH(bpr_pkg::PALETTE_SIZE)) u_ram_g (
        .aclk  (aclk),
        .we    (ctl.pal_we[1]),
        .waddr (ctl.pal_waddr),
        .wdata (ctl.pal_wdata),
        .re    (ctl.pal_re),
        .raddr (ctl.pal_raddr),
        .rdata (pal_g)
    );

    bpr_ram #(.WIDTH(8), .DEPTH(bpr_pkg::PALETTE_SIZE)) u_ram_r (
        .aclk  (aclk),
        .we    (ctl.pal_we[2]),
        .waddr (ctl.pal_waddr),
        .wdata (ctl.pal_wdata),
        .re    (ctl.pal_re),
        .raddr (ctl.pal_raddr),
        .rdata (pal_r)
    );

    always_comb begin
        if (accept) begin
            s1_valid_next = ctl.emit;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        m_valid_next = out_free ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && ctl.emit) begin
            s1_pal_reg  <= ctl.use_pal;
            s1_word_reg <= ctl.word;
            s1_last_reg <= ctl.last;
        end
        if (out_free && s1_valid_reg) begin
            m_word_reg <= s1_pal_reg ? {8'h00, pal_b, pal_g, pal_r} : s1_word_reg;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_word = m_word_reg;
    assign m_last_pixel = m_last_reg;

endmodule
